// File: rtl/rna_base_pair_fold_dp_assert.svh
// Assertion macros for the folding block. Each use sits on a line of its own.
`ifndef RNA_BASE_PAIR_FOLD_DP_ASSERT_SVH
`define RNA_BASE_PAIR_FOLD_DP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rbpf_pkg.sv
`timescale 1ns / 1ps
package rbpf_pkg;

  localparam int MAX_LEN   = 512;
  localparam int POS_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = POS_W + 1;
  localparam int SCORE_W   = 9;
  localparam int BASE_W    = 3;
  localparam int TBL_DEPTH = MAX_LEN * MAX_LEN;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_RUN    = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  localparam logic [BASE_W-1:0] BASE_A = 3'd0;
  localparam logic [BASE_W-1:0] BASE_G = 3'd1;
  localparam logic [BASE_W-1:0] BASE_C = 3'd2;
  localparam logic [BASE_W-1:0] BASE_U = 3'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [BASE_W-1:0] base;
    logic [8:0]        row;
    logic [8:0]        col;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIAG,
    ST_SCAN,
    ST_DRAIN,
    ST_WB
  } fold_state_t;

  typedef enum logic [1:0] {
    RK_NONE,
    RK_DIAG,
    RK_PAIR
  } rd_kind_t;

  // Watson-Crick pairs plus the GU wobble, in either order. Unknown codes never pair.
  function automatic logic can_pair(input logic [BASE_W-1:0] a, input logic [BASE_W-1:0] b);
    logic p;
    p = ((a == BASE_A) && (b == BASE_U)) || ((a == BASE_U) && (b == BASE_A)) ||
        ((a == BASE_G) && (b == BASE_C)) || ((a == BASE_C) && (b == BASE_G)) ||
        ((a == BASE_G) && (b == BASE_U)) || ((a == BASE_U) && (b == BASE_G));
    return p;
  endfunction

endpackage

// File: rtl/rna_base_pair_fold_dp.sv
`timescale 1ns / 1ps
// Maximum base-pair folding engine with an on-chip score table.
// Input channel (in_valid/in_ready/in_data) takes one request per beat:
// append a base, run the fill, read one table cell, or clear the sequence.
// Output channel (out_valid/out_ready/out_data) returns exactly one beat per
// request, held in an output register until the receiver takes it.
// Append, clear, a short run and an out-of-range read answer in the
// cycle after acceptance; an in-range read passes through the registered
// table read port and then the output register. A run on n bases walks
// every cell (i,j), i<j, in states DIAG, SCAN, DRAIN and WB; in SCAN the
// pair of table read ports fetch one split point k per cycle. Requests
// are handled one at a time; in_ready is high only when the engine is
// idle and the output register is free or draining.
// A stalled receiver holds the result and blocks the next request.
// Reset clears the base count and the record of the last run, which makes
// the whole table read as zero; no clearing pass runs over the memory, and
// cells outside the last run's range or on or below the diagonal read as zero.
`include "rna_base_pair_fold_dp_assert.svh"

module rna_base_pair_fold_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rbpf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rbpf_pkg::out_item_t out_data
);

  localparam int POS_W   = rbpf_pkg::POS_W;
  localparam int CNT_W   = rbpf_pkg::CNT_W;
  localparam int SCORE_W = rbpf_pkg::SCORE_W;
  localparam int BASE_W  = rbpf_pkg::BASE_W;

  rbpf_pkg::fold_state_t state_r, state_nxt;
  rbpf_pkg::rd_kind_t    kind_r, kind_nxt;

  logic [CNT_W-1:0]   base_count_r, base_count_nxt;
  logic [CNT_W-1:0]   run_n_r, run_n_nxt;
  logic [POS_W-1:0]   i_r, i_nxt;
  logic [POS_W-1:0]   j_r, j_nxt;
  logic [POS_W-1:0]   k_r, k_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic               out_valid_r, out_valid_nxt;
  rbpf_pkg::out_item_t out_data_r, out_data_nxt;

  logic [SCORE_W-1:0] rd_a_r, rd_b_r;
  logic               mask_a_r, mask_b_r;
  logic [BASE_W-1:0]  base_i_r, base_j_r;

  logic [SCORE_W-1:0] score_mem [rbpf_pkg::TBL_DEPTH];
  logic [BASE_W-1:0]  base_mem  [rbpf_pkg::MAX_LEN];

  logic               accept;
  logic               tbl_we;
  logic [POS_W-1:0]   ra_row, ra_col, rb_row, rb_col;
  logic               mask_a, mask_b;
  logic               j_last;
  logic               row_bad, col_bad;
  logic [CNT_W-1:0]   cnt_m1, cnt_m2;
  logic [SCORE_W-1:0] val_a, val_b;
  logic [SCORE_W:0]   pair_sum;
  logic               in_scan;
  logic               wr_in_tri;

  assign accept  = in_valid && in_ready;
  assign j_last  = ({1'b0, j_r} + CNT_W'(1)) == run_n_r;
  assign row_bad = {1'b0, in_data.row} >= base_count_r;
  assign col_bad = {1'b0, in_data.col} >= base_count_r;
  assign cnt_m1  = base_count_r - CNT_W'(1);
  assign cnt_m2  = base_count_r - CNT_W'(2);

  // A cell holds live data only above the diagonal and inside the last run.
  assign mask_a = (ra_row < ra_col) && ({1'b0, ra_col} < run_n_r);
  assign mask_b = (rb_row < rb_col) && ({1'b0, rb_col} < run_n_r);

  assign val_a    = mask_a_r ? rd_a_r : '0;
  assign val_b    = mask_b_r ? rd_b_r : '0;
  assign pair_sum = {1'b0, val_a} + {1'b0, val_b};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rbpf_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            rbpf_pkg::REQ_RUN: begin
              if (base_count_r >= CNT_W'(2)) begin
                state_nxt = rbpf_pkg::ST_DIAG;
              end
            end
            rbpf_pkg::REQ_READ: begin
              if (!row_bad && !col_bad) begin
                state_nxt = rbpf_pkg::ST_READ;
              end
            end
            default: state_nxt = rbpf_pkg::ST_IDLE;
          endcase
        end
      end
      rbpf_pkg::ST_READ: state_nxt = rbpf_pkg::ST_IDLE;
      rbpf_pkg::ST_DIAG: state_nxt = rbpf_pkg::ST_SCAN;
      rbpf_pkg::ST_SCAN: begin
        if ((k_r + POS_W'(1)) == j_r) begin
          state_nxt = rbpf_pkg::ST_DRAIN;
        end
      end
      rbpf_pkg::ST_DRAIN: state_nxt = rbpf_pkg::ST_WB;
      rbpf_pkg::ST_WB: begin
        if (j_last && (i_r == '0)) begin
          state_nxt = rbpf_pkg::ST_IDLE;
        end else begin
          state_nxt = rbpf_pkg::ST_DIAG;
        end
      end
      default: state_nxt = rbpf_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: handshake, table read addresses and write enable.
  always_comb begin
    in_ready = 1'b0;
    tbl_we   = 1'b0;
    kind_nxt = rbpf_pkg::RK_NONE;
    ra_row   = in_data.row;
    ra_col   = in_data.col;
    rb_row   = k_r + POS_W'(1);
    rb_col   = j_r;
    case (state_r)
      rbpf_pkg::ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      rbpf_pkg::ST_DIAG: begin
        ra_row   = i_r + POS_W'(1);
        ra_col   = j_r - POS_W'(1);
        kind_nxt = rbpf_pkg::RK_DIAG;
      end
      rbpf_pkg::ST_SCAN: begin
        ra_row   = i_r;
        ra_col   = k_r;
        kind_nxt = rbpf_pkg::RK_PAIR;
      end
      rbpf_pkg::ST_WB: begin
        tbl_we = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    base_count_nxt = base_count_r;
    run_n_nxt      = run_n_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    // The read data landing this cycle belongs to the previous cycle's issue.
    case (kind_r)
      rbpf_pkg::RK_DIAG: begin
        best_nxt = val_a + SCORE_W'(rbpf_pkg::can_pair(base_i_r, base_j_r));
      end
      rbpf_pkg::RK_PAIR: begin
        if (pair_sum > {1'b0, best_r}) begin
          best_nxt = pair_sum[SCORE_W-1:0];
        end
      end
      default: best_nxt = best_r;
    endcase

    case (state_r)
      rbpf_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.score  = '0;
          out_data_nxt.status = rbpf_pkg::STAT_OK;
          case (in_data.req_type)
            rbpf_pkg::REQ_APPEND: begin
              if (base_count_r < CNT_W'(rbpf_pkg::MAX_LEN)) begin
                base_count_nxt = base_count_r + CNT_W'(1);
              end else begin
                out_data_nxt.status = rbpf_pkg::STAT_FULL;
              end
            end
            rbpf_pkg::REQ_RUN: begin
              run_n_nxt = base_count_r;
              i_nxt     = cnt_m2[POS_W-1:0];
              j_nxt     = cnt_m1[POS_W-1:0];
              if (base_count_r >= CNT_W'(2)) begin
                out_valid_nxt = 1'b0;
              end
            end
            rbpf_pkg::REQ_READ: begin
              if (row_bad || col_bad) begin
                out_data_nxt.status = rbpf_pkg::STAT_RANGE;
              end else begin
                out_valid_nxt = 1'b0;
              end
            end
            default: begin
              base_count_nxt = '0;
            end
          endcase
        end
      end
      rbpf_pkg::ST_READ: begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.score  = val_a;
        out_data_nxt.status = rbpf_pkg::STAT_OK;
      end
      rbpf_pkg::ST_DIAG: begin
        k_nxt = i_r;
      end
      rbpf_pkg::ST_SCAN: begin
        k_nxt = k_r + POS_W'(1);
      end
      rbpf_pkg::ST_WB: begin
        if (j_last) begin
          if (i_r == '0) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.score  = best_r;
            out_data_nxt.status = rbpf_pkg::STAT_OK;
          end else begin
            i_nxt = i_r - POS_W'(1);
            j_nxt = i_r;
          end
        end else begin
          j_nxt = j_r + POS_W'(1);
        end
      end
      default: begin
        k_nxt = k_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rbpf_pkg::ST_IDLE;
      kind_r       <= rbpf_pkg::RK_NONE;
      base_count_r <= '0;
      run_n_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kind_r       <= kind_nxt;
      base_count_r <= base_count_nxt;
      run_n_r      <= run_n_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
    mask_a_r   <= mask_a;
    mask_b_r   <= mask_b;
  end

  // Score table: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      score_mem[{i_r, j_r}] <= best_r;
    end
    rd_a_r <= score_mem[{ra_row, ra_col}];
    rd_b_r <= score_mem[{rb_row, rb_col}];
  end

  // Base store: written on append, both pair ends read during a fill.
  always_ff @(posedge clk) begin
    if (accept && (in_data.req_type == rbpf_pkg::REQ_APPEND) &&
        (base_count_r < CNT_W'(rbpf_pkg::MAX_LEN))) begin
      base_mem[base_count_r[POS_W-1:0]] <= in_data.base;
    end
    base_i_r <= base_mem[i_r];
    base_j_r <= base_mem[j_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_scan   = state_r == rbpf_pkg::ST_SCAN;
  assign wr_in_tri = (i_r < j_r) && ({1'b0, j_r} < run_n_r);

  `RBPF_ASSERT_NOW(a_wr_above_diag, tbl_we, wr_in_tri, "fill wrote outside the triangle")
  `RBPF_ASSERT_NOW(a_scan_split, in_scan, (k_r >= i_r) && (k_r < j_r), "split point out of range")
  `RBPF_ASSERT_NOW(a_fill_out_free, in_scan, !out_valid_r, "result register busy in a fill")
  `RBPF_ASSERT_NEXT(a_scan_tag, in_scan, kind_r == rbpf_pkg::RK_PAIR, "scan read untagged")

endmodule

// File: tb/tb_rna_base_pair_fold_dp.sv
`timescale 1ns / 1ps
module tb_rna_base_pair_fold_dp;

  localparam int MAX_LEN = rbpf_pkg::MAX_LEN;
  localparam int SCORE_W = rbpf_pkg::SCORE_W;
  localparam int BASE_W  = rbpf_pkg::BASE_W;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  rbpf_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  rbpf_pkg::out_item_t out_data;

  rna_base_pair_fold_dp dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Longest sequence that the random part ever folds; keeps run times modest.
  localparam int FOLD_CAP = 56;

  // Mirror of the folding engine's state.
  logic [BASE_W-1:0]  seq_base [MAX_LEN];
  int                 seq_len = 0;
  bit   [SCORE_W-1:0] pair_tbl [MAX_LEN][MAX_LEN];
  int                 filled_len = 0;

  rbpf_pkg::out_item_t pending_answers[$];

  int fail_count   = 0;
  int sent_count   = 0;
  int run_count    = 0;
  int read_count   = 0;
  int append_count = 0;
  int longest_run  = 0;
  bit idle_on      = 1'b1;
  bit hold_req     = 1'b0;

  // Applies one request to the mirror state and returns the answer it must produce.
  function automatic rbpf_pkg::out_item_t fold_answer(input rbpf_pkg::in_item_t req);
    rbpf_pkg::out_item_t ans;
    int                  best;
    int                  cand;
    ans        = '0;
    ans.status = rbpf_pkg::STAT_OK;
    case (req.req_type)
      rbpf_pkg::REQ_APPEND: begin
        append_count++;
        if (seq_len >= MAX_LEN) begin
          ans.status = rbpf_pkg::STAT_FULL;
        end else begin
          seq_base[seq_len] = req.base;
          seq_len++;
        end
      end
      rbpf_pkg::REQ_RUN: begin
        run_count++;
        if (seq_len > longest_run) longest_run = seq_len;
        // Only the square touched by the previous run can hold nonzero cells.
        for (int a = 0; a < filled_len; a++) begin
          for (int b = 0; b < filled_len; b++) pair_tbl[a][b] = '0;
        end
        filled_len = seq_len;
        for (int i = seq_len - 2; i >= 0; i--) begin
          for (int j = i + 1; j < seq_len; j++) begin
            best = 0;
            for (int k = i; k < j; k++) begin
              cand = pair_tbl[i][k] + pair_tbl[k + 1][j];
              if (cand > best) best = cand;
            end
            case ({seq_base[i], seq_base[j]})
              {rbpf_pkg::BASE_A, rbpf_pkg::BASE_U}, {rbpf_pkg::BASE_U, rbpf_pkg::BASE_A},
              {rbpf_pkg::BASE_G, rbpf_pkg::BASE_C}, {rbpf_pkg::BASE_C, rbpf_pkg::BASE_G},
              {rbpf_pkg::BASE_G, rbpf_pkg::BASE_U}, {rbpf_pkg::BASE_U, rbpf_pkg::BASE_G}:
              begin
                cand = pair_tbl[i + 1][j - 1] + 1;
              end
              default: begin
                cand = pair_tbl[i + 1][j - 1];
              end
            endcase
            if (cand > best) best = cand;
            pair_tbl[i][j] = best[SCORE_W-1:0];
          end
        end
        if (seq_len >= 2) ans.score = pair_tbl[0][seq_len - 1];
      end
      rbpf_pkg::REQ_READ: begin
        read_count++;
        if (req.row >= seq_len || req.col >= seq_len) begin
          ans.status = rbpf_pkg::STAT_RANGE;
        end else begin
          ans.score = pair_tbl[req.row][req.col];
        end
      end
      rbpf_pkg::REQ_CLEAR: begin
        seq_len = 0;
      end
    endcase
    return ans;
  endfunction

  task automatic send_req(input rbpf_pkg::in_item_t req);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_answers.push_back(fold_answer(req));
    sent_count++;
  endtask

  task automatic send_base(input int code);
    rbpf_pkg::in_item_t req;
    req.req_type = rbpf_pkg::REQ_APPEND;
    req.base     = 3'(code);
    req.row      = 9'($urandom_range(0, 511));
    req.col      = 9'($urandom_range(0, 511));
    send_req(req);
  endtask

  task automatic send_read(input int r, input int c);
    rbpf_pkg::in_item_t req;
    req.req_type = rbpf_pkg::REQ_READ;
    req.base     = 3'($urandom_range(0, 7));
    req.row      = 9'(r);
    req.col      = 9'(c);
    send_req(req);
  endtask

  task automatic send_op(input logic [1:0] kind);
    rbpf_pkg::in_item_t req;
    req.req_type = kind;
    req.base     = 3'($urandom_range(0, 7));
    req.row      = 9'($urandom_range(0, 511));
    req.col      = 9'($urandom_range(0, 511));
    send_req(req);
  endtask

  task automatic check_result(input rbpf_pkg::out_item_t got);
    rbpf_pkg::out_item_t want;
    if (pending_answers.size() == 0) begin
      $error("result beat with no request outstanding: score %0d status %0d",
             got.score, got.status);
      fail_count++;
    end else begin
      want = pending_answers.pop_front();
      if (got.score !== want.score) begin
        $error("score mismatch: expected %0d, actual %0d", want.score, got.score);
        fail_count++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        fail_count++;
      end
    end
  endtask

  // Receiver: takes result beats, stalls in random bursts, and honors long hold-offs.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_result(out_data);
      if (hold_req) begin
        stall_left = 300;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_short_runs();
    send_op(rbpf_pkg::REQ_RUN);
    send_read(0, 0);
    send_base(rbpf_pkg::BASE_U);
    send_op(rbpf_pkg::REQ_RUN);
    send_read(0, 0);
    send_op(rbpf_pkg::REQ_CLEAR);
  endtask

  // Every pairing rule but UA appears next to its neighbor, plus unknown codes 4 to 7.
  task automatic test_pair_rules();
    int codes [16];
    codes = '{rbpf_pkg::BASE_A, rbpf_pkg::BASE_U, rbpf_pkg::BASE_G, rbpf_pkg::BASE_C,
              rbpf_pkg::BASE_G, rbpf_pkg::BASE_U, rbpf_pkg::BASE_U, rbpf_pkg::BASE_G,
              rbpf_pkg::BASE_C, rbpf_pkg::BASE_A, 4, 7, rbpf_pkg::BASE_U, 5,
              rbpf_pkg::BASE_A, 6};
    foreach (codes[n]) send_base(codes[n]);
    send_op(rbpf_pkg::REQ_RUN);
    send_read(0, 1);
    send_read(2, 3);
    send_read(4, 5);
    send_read(6, 7);
    send_read(8, 9);
    send_read(10, 11);
    send_read(12, 15);
    send_read(5, 5);
    send_read(9, 3);
    send_read(16, 0);
    send_read(0, 16);
    send_read(511, 511);
  endtask

  // After a clear the table keeps the old run's cells until the next run.
  task automatic test_stale_after_clear();
    send_op(rbpf_pkg::REQ_CLEAR);
    repeat (4) send_base($urandom_range(0, 3));
    send_read(0, 3);
    send_read(1, 2);
    send_read(2, 0);
    send_op(rbpf_pkg::REQ_RUN);
    send_read(0, 3);
    send_read(1, 3);
  endtask

  task automatic test_full_sequence();
    send_op(rbpf_pkg::REQ_CLEAR);
    repeat (MAX_LEN) send_base($urandom_range(0, 7));
    send_base(7);
    send_base(rbpf_pkg::BASE_A);
    send_read(511, 511);
    send_read(0, 511);
    send_read(511, 0);
    send_read(510, 511);
    send_op(rbpf_pkg::REQ_CLEAR);
    send_read(0, 0);
  endtask

  // The receiver stops for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_op(rbpf_pkg::REQ_CLEAR);
    repeat (6) send_base($urandom_range(0, 3));
    send_op(rbpf_pkg::REQ_RUN);
    send_read(0, 5);
    send_read(1, 4);
    send_read(2, 2);
  endtask

  task automatic test_random_folds();
    int         start;
    int         len;
    int         pick;
    int         r;
    int         c;
    int         tmp;
    logic [1:0] kind;
    start = sent_count;
    while (sent_count - start < 120) begin
      if (sent_count - start > 80) idle_on = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          kind = 2'($urandom_range(0, 3));
          if (kind == rbpf_pkg::REQ_RUN && seq_len > FOLD_CAP) kind = rbpf_pkg::REQ_CLEAR;
          send_op(kind);
        end
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) len = $urandom_range(0, 1);
      else if (pick == 1) len = $urandom_range(21, FOLD_CAP);
      else len = $urandom_range(2, 20);
      if ($urandom_range(0, 7) != 0 || seq_len + len > FOLD_CAP) begin
        send_op(rbpf_pkg::REQ_CLEAR);
      end
      repeat (len) begin
        if ($urandom_range(0, 6) == 0) send_base($urandom_range(4, 7));
        else send_base($urandom_range(0, 3));
      end
      send_op(rbpf_pkg::REQ_RUN);
      repeat ($urandom_range(2, 8)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7 && seq_len > 0) begin
          r = $urandom_range(0, seq_len - 1);
          c = $urandom_range(0, seq_len - 1);
          if (pick < 5 && r > c) begin
            tmp = r;
            r   = c;
            c   = tmp;
          end
        end else begin
          r = $urandom_range(0, 511);
          c = $urandom_range(0, 511);
        end
        send_read(r, c);
      end
    end
  endtask

  initial begin : stimulus
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_runs();
    test_pair_rules();
    test_stale_after_clear();
    test_full_sequence();
    test_backpressure();
    test_random_folds();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d requests: %0d appends, %0d fill runs (longest %0d bases), %0d reads.",
             sent_count, append_count, run_count, longest_run, read_count);
    $display("Included a full sequence, unknown bases, stale reads and a long receiver stall.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(50_000_000);
    $display("timeout: requests or results stopped moving");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
